// ===== src/button_press_classifier_macros.svh =====
// Assertion macros shared by the button press classifier modules
`ifndef BUTTON_PRESS_CLASSIFIER_MACROS_SVH
`define BUTTON_PRESS_CLASSIFIER_MACROS_SVH

// check a condition in the same cycle as its trigger
`define BPC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// check a condition in the cycle after its trigger
`define BPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/bpc_pkg.sv =====
// Shared types and constants for the button press classifier
package bpc_pkg;

  localparam int unsigned MASK_W         = 4;
  localparam int unsigned DEBOUNCE_W     = 8;
  localparam int unsigned LONG_W         = 16;
  localparam int unsigned CFG_INDEX_W    = 2;
  localparam int unsigned CFG_DATA_W     = 16;
  localparam int unsigned BUTTON_COUNT_DEF = 4;
  localparam int unsigned COUNTER_BITS_DEF = 16;

  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 8'd50;
  localparam logic [LONG_W-1:0]     LONG_RESET     = 16'd1000;

  localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LONG_PRESS = 2'd1;

  typedef struct packed {
    logic [DEBOUNCE_W-1:0] debounce_ticks;
    logic [LONG_W-1:0]     long_press_ticks;
  } cfg_t;

  typedef struct packed {
    logic [MASK_W-1:0] short_press_mask;
    logic [MASK_W-1:0] long_press_mask;
    logic              any_event;
  } res_t;

endpackage

// ===== src/bpc_lane.sv =====
// Per-button debounce and short/long press detection lane
module bpc_lane #(
  parameter int unsigned COUNTER_BITS = bpc_pkg::COUNTER_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  logic          raw,
  input  bpc_pkg::cfg_t cfg,
  output logic          short_ev,
  output logic          long_ev
);

  localparam int unsigned CMP_W =
    (COUNTER_BITS > bpc_pkg::LONG_W) ? COUNTER_BITS : bpc_pkg::LONG_W;
  localparam logic [COUNTER_BITS-1:0] CNT_MAX = {COUNTER_BITS{1'b1}};

  logic                    last_level_r, last_level_nxt;
  logic [COUNTER_BITS-1:0] stable_ticks_r, stable_ticks_nxt;
  logic                    held_state_r, held_state_nxt;
  logic [COUNTER_BITS-1:0] press_ticks_r, press_ticks_nxt;
  logic                    long_done_r, long_done_nxt;
  logic [COUNTER_BITS-1:0] press_inc;
  logic                    qualified;
  logic                    long_reached;

  always_comb begin
    last_level_nxt   = raw;
    stable_ticks_nxt = (raw != last_level_r) ? '0 :
                       ((stable_ticks_r == CNT_MAX) ? CNT_MAX : stable_ticks_r + 1'b1);
    press_inc        = (press_ticks_r == CNT_MAX) ? CNT_MAX : press_ticks_r + 1'b1;
    qualified        = stable_ticks_nxt > COUNTER_BITS'(cfg.debounce_ticks);
    long_reached     = CMP_W'(press_inc) >= CMP_W'(cfg.long_press_ticks);
    held_state_nxt   = held_state_r;
    press_ticks_nxt  = press_inc;
    long_done_nxt    = long_done_r;
    short_ev         = 1'b0;
    long_ev          = 1'b0;
    if (qualified) begin
      if (!raw && held_state_r) begin
        held_state_nxt  = 1'b0;
        press_ticks_nxt = '0;
        long_done_nxt   = 1'b0;
      end else if (!raw) begin
        if (!long_done_r && long_reached) begin
          long_done_nxt = 1'b1;
          long_ev       = 1'b1;
        end
      end else if (!held_state_r) begin
        held_state_nxt = 1'b1;
        short_ev       = !long_done_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_level_r   <= 1'b1;
      stable_ticks_r <= '0;
      held_state_r   <= 1'b1;
      press_ticks_r  <= '0;
      long_done_r    <= 1'b0;
    end else if (accept) begin
      last_level_r   <= last_level_nxt;
      stable_ticks_r <= stable_ticks_nxt;
      held_state_r   <= held_state_nxt;
      press_ticks_r  <= press_ticks_nxt;
      long_done_r    <= long_done_nxt;
    end
  end

endmodule

// ===== src/bpc_merge.sv =====
// Merge of lane events into result items, with output register and skid stage
`include "button_press_classifier_macros.svh"

module bpc_merge #(
  parameter int unsigned BUTTON_COUNT = bpc_pkg::BUTTON_COUNT_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    accept,
  input  logic [BUTTON_COUNT-1:0] short_vec,
  input  logic [BUTTON_COUNT-1:0] long_vec,
  output logic                    in_stall,
  output logic                    out_valid,
  input  logic                    out_stall,
  output bpc_pkg::res_t           out_res
);

  bpc_pkg::res_t res_new;
  bpc_pkg::res_t out_res_r;
  bpc_pkg::res_t skid_res_r;
  logic          out_valid_r;
  logic          skid_valid_r;
  logic          out_free;

  for (genvar b = 0; b < bpc_pkg::MASK_W; b++) begin : g_mask
    if (b < BUTTON_COUNT) begin : g_lane
      assign res_new.short_press_mask[b] = short_vec[b];
      assign res_new.long_press_mask[b]  = long_vec[b];
    end else begin : g_none
      assign res_new.short_press_mask[b] = 1'b0;
      assign res_new.long_press_mask[b]  = 1'b0;
    end
  end
  assign res_new.any_event = |{short_vec, long_vec};

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_free) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (accept) begin
      if (out_free) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_free) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_free) begin
        out_res_r <= skid_res_r;
      end
    end else if (accept) begin
      if (out_free) begin
        out_res_r <= res_new;
      end else begin
        skid_res_r <= res_new;
      end
    end
  end

  `BPC_ASSERT_NOW(a_skid_needs_out, clk, rst_n, skid_valid_r, out_valid_r, "skid full while output empty")
  `BPC_ASSERT_NOW(a_any_covers_masks, clk, rst_n, out_valid_r && ((out_res_r.short_press_mask | out_res_r.long_press_mask) != '0), out_res_r.any_event, "mask bit set without any_event")
  `BPC_ASSERT_NEXT(a_accept_shows, clk, rst_n, accept && !out_valid_r, out_valid_r && !skid_valid_r, "accepted item not presented")

endmodule

// ===== src/button_press_classifier.sv =====
// Top level of the button press classifier: config registers, button lanes, merge
// A result item is registered in the output register, or in the skid entry while out_stall holds the output.
// Throughput: one tick item per cycle while in_stall is low; every lane updates in the accepting cycle.
// A two-entry output stage (register plus skid) keeps in_stall registered.
// Reset: all buttons released, counters cleared, debounce 50 and long press 1000 ticks.
// Reset empties the output stage; no clearing pass is needed.
module button_press_classifier #(
  parameter int unsigned BUTTON_COUNT = bpc_pkg::BUTTON_COUNT_DEF,
  parameter int unsigned COUNTER_BITS = bpc_pkg::COUNTER_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [bpc_pkg::MASK_W-1:0]        in_raw_levels,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [bpc_pkg::MASK_W-1:0]        out_short_press_mask,
  output logic [bpc_pkg::MASK_W-1:0]        out_long_press_mask,
  output logic                              out_any_event,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bpc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [bpc_pkg::CFG_DATA_W-1:0]    cfg_data
);

  bpc_pkg::cfg_t           cfg_r;
  bpc_pkg::res_t           res;
  logic                    accept;
  logic [BUTTON_COUNT-1:0] raw_vec;
  logic [BUTTON_COUNT-1:0] short_vec;
  logic [BUTTON_COUNT-1:0] long_vec;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks   <= bpc_pkg::DEBOUNCE_RESET;
      cfg_r.long_press_ticks <= bpc_pkg::LONG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bpc_pkg::REG_DEBOUNCE: begin
          cfg_r.debounce_ticks <= cfg_data[bpc_pkg::DEBOUNCE_W-1:0];
        end
        bpc_pkg::REG_LONG_PRESS: begin
          cfg_r.long_press_ticks <= cfg_data[bpc_pkg::LONG_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  for (genvar b = 0; b < BUTTON_COUNT; b++) begin : g_lane
    if (b < bpc_pkg::MASK_W) begin : g_pin
      assign raw_vec[b] = in_raw_levels[b];
    end else begin : g_nopin
      assign raw_vec[b] = 1'b0;
    end

    bpc_lane #(
      .COUNTER_BITS(COUNTER_BITS)
    ) u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .accept   (accept),
      .raw      (raw_vec[b]),
      .cfg      (cfg_r),
      .short_ev (short_vec[b]),
      .long_ev  (long_vec[b])
    );
  end

  bpc_merge #(
    .BUTTON_COUNT(BUTTON_COUNT)
  ) u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .short_vec (short_vec),
    .long_vec  (long_vec),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (res)
  );

  assign out_short_press_mask = res.short_press_mask;
  assign out_long_press_mask  = res.long_press_mask;
  assign out_any_event        = res.any_event;

endmodule
